// ===== rtl/cia_pkg.sv =====
// ----------------------------------------------------------------------------
// cia_pkg
// shared types for the checked integer alu: operation and error codes and the
// per-item control word that travels down the pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_ABS = 3'd5,
    OP_MIN = 3'd6,
    OP_MAX = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_OVF  = 2'd1,
    ERR_DIV0 = 2'd2
  } err_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    err_e err;     // error known at decode time
    logic neg_q;   // quotient sign
    logic neg_r;   // remainder sign
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/cia_prep.sv =====
// ----------------------------------------------------------------------------
// cia_prep
// decode stage: sign extension, magnitudes, the simple operations and
// the error cases that are known from the operands alone
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_prep #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic [2:0]            command_i,
  input  wire logic [63:0]           operand_a_i,
  input  wire logic [63:0]           operand_b_i,
  output cia_pkg::ctrl_t             ctrl_o,
  output logic [DATA_WIDTH-1:0]      simple_o,
  output logic [DATA_WIDTH-1:0]      mag_a_o,
  output logic [DATA_WIDTH-1:0]      mag_b_o,
  output logic                       mul_neg_o
);
  import cia_pkg::*;

  localparam int W = DATA_WIDTH;

  logic [W-1:0] a, b, mag_a, mag_b, simple_d, wmin, wmax;
  logic [W:0]   sum, dif;
  ctrl_t        ctrl_d, ctrl_q;
  logic [W-1:0] simple_q, mag_a_q, mag_b_q;
  logic         mul_neg_q;

  assign a     = operand_a_i[W-1:0];
  assign b     = operand_b_i[W-1:0];
  assign wmin  = {1'b1, {(W-1){1'b0}}};
  assign wmax  = {1'b0, {(W-1){1'b1}}};
  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;
  assign sum   = {a[W-1], a} + {b[W-1], b};
  assign dif   = {a[W-1], a} - {b[W-1], b};

  always_comb begin
    ctrl_d.valid = accept_i;
    ctrl_d.op    = op_e'(command_i);
    ctrl_d.err   = ERR_NONE;
    ctrl_d.neg_q = a[W-1] ^ b[W-1];
    ctrl_d.neg_r = a[W-1];
    simple_d     = '0;
    case (ctrl_d.op)
      OP_ADD: begin
        simple_d = sum[W-1:0];
        if (sum[W] != sum[W-1]) ctrl_d.err = ERR_OVF;
      end
      OP_SUB: begin
        simple_d = dif[W-1:0];
        if (dif[W] != dif[W-1]) ctrl_d.err = ERR_OVF;
      end
      OP_DIV: begin
        if (b == '0) ctrl_d.err = ERR_DIV0;
        else if (a == wmin && b == '1) ctrl_d.err = ERR_OVF;
      end
      OP_MOD: begin
        if (b == '0) ctrl_d.err = ERR_DIV0;
      end
      OP_ABS:  simple_d = (a == wmin) ? wmax : mag_a;
      OP_MIN:  simple_d = ($signed(a) < $signed(b)) ? a : b;
      OP_MAX:  simple_d = ($signed(b) < $signed(a)) ? a : b;
      default: simple_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    simple_q  <= simple_d;
    mag_a_q   <= mag_a;
    mag_b_q   <= mag_b;
    mul_neg_q <= ctrl_d.neg_q;
  end

  assign ctrl_o    = ctrl_q;
  assign simple_o  = simple_q;
  assign mag_a_o   = mag_a_q;
  assign mag_b_o   = mag_b_q;
  assign mul_neg_o = mul_neg_q;

endmodule

`default_nettype wire

// ===== rtl/cia_mul.sv =====
// ----------------------------------------------------------------------------
// cia_mul
// three-stage magnitude multiplier: half-width partial products, full-width
// sum, then exact overflow check and sign
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_mul #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic [DATA_WIDTH-1:0] mag_a_i,
  input  wire logic [DATA_WIDTH-1:0] mag_b_i,
  input  wire logic                  neg_i,
  output logic [DATA_WIDTH-1:0]      res_o,
  output logic                       ovf_o
);
  localparam int W = DATA_WIDTH;
  localparam int H = W / 2;
  localparam int U = W - H;

  logic [2*H-1:0] p00_q;
  logic [H+U-1:0] p01_q, p10_q;
  logic [2*U-1:0] p11_q;
  logic           neg1_q, neg2_q;
  logic [2*W-1:0] prod_d, prod_q;
  logic [W-1:0]   lo, limit, res_q;
  logic           ovf_q;

  // stage one: partial products
  always_ff @(posedge clk_i) begin
    p00_q  <= mag_a_i[H-1:0] * mag_b_i[H-1:0];
    p01_q  <= mag_a_i[H-1:0] * mag_b_i[W-1:H];
    p10_q  <= mag_a_i[W-1:H] * mag_b_i[H-1:0];
    p11_q  <= mag_a_i[W-1:H] * mag_b_i[W-1:H];
    neg1_q <= neg_i;
  end

  assign prod_d = {{(2*W-2*H){1'b0}}, p00_q}
                + ({{(2*W-H-U){1'b0}}, p01_q} << H)
                + ({{(2*W-H-U){1'b0}}, p10_q} << H)
                + ({{(2*W-2*U){1'b0}}, p11_q} << (2*H));

  // stage two: full product
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg2_q <= neg1_q;
  end

  // largest magnitude that still fits, one more when negative
  assign lo    = prod_q[W-1:0];
  assign limit = {1'b0, {(W-1){1'b1}}} + {{(W-1){1'b0}}, neg2_q};

  // stage three: check and sign
  always_ff @(posedge clk_i) begin
    ovf_q <= (|prod_q[2*W-1:W]) || (lo > limit);
    res_q <= neg2_q ? (~lo + 1'b1) : lo;
  end

  assign res_o = res_q;
  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/cia_div.sv =====
// ----------------------------------------------------------------------------
// cia_div
// restoring magnitude divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_div #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output logic [DATA_WIDTH-1:0]      quot_o,
  output logic [DATA_WIDTH-1:0]      rem_o
);
  localparam int W = DATA_WIDTH;

  logic [W-1:0] rem_q [W];
  logic [W-1:0] dq_q  [W];
  logic [W-1:0] dv_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0] rem_in, dq_in, dv_in;
    logic [W:0]   shifted, trial;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign dv_in  = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign dv_in  = dv_q[k-1];
    end

    assign shifted = {rem_in, dq_in[W-1]};
    assign trial   = shifted - {1'b0, dv_in};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= trial[W] ? shifted[W-1:0] : trial[W-1:0];
      dq_q[k]  <= {dq_in[W-2:0], ~trial[W]};
      dv_q[k]  <= dv_in;
    end
  end

  assign quot_o = dq_q[W-1];
  assign rem_o  = rem_q[W-1];

endmodule

`default_nettype wire

// ===== rtl/checked_integer_alu.sv =====
// ----------------------------------------------------------------------------
// checked_integer_alu
// overflow-checked signed integer alu: add, sub, mul, div, mod, abs, min, max
// ----------------------------------------------------------------------------
//
//  channel   signals                                  direction
//  command   start_i, busy_o, command_i,              in
//            operand_a_i, operand_b_i
//  result    done_o, result_o, error_o                out
//
//  one item per cycle, every cycle; an item passes the decode stage, the
//  divider or its matching delay line, then the output register of done_o;
//  the divider makes one quotient bit per register stage, and every other
//  operation is delayed to match so results leave in order
//  busy_o is always low: the pipeline never stalls and the receiver cannot
//  hold results off
//  reset clears the valid bits only; no item is in flight afterwards
//
`timescale 1ns / 1ps
`default_nettype none

module checked_integer_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  output logic             done_o,
  output logic [63:0]      result_o,
  output logic [1:0]       error_o
);
  import cia_pkg::*;

  localparam int W      = DATA_WIDTH;
  localparam int MUL_LAT = 3;           // stages inside the multiplier
  localparam int MUL_DLY = W - MUL_LAT; // extra delay to line up with divider

  // decode stage outputs
  ctrl_t        p_ctrl;
  logic [W-1:0] p_simple, p_mag_a, p_mag_b;
  logic         p_mul_neg;

  // unit outputs
  logic [W-1:0] m_res, d_quot, d_rem;
  logic         m_ovf;

  // side line: control word and simple result, delayed to the divider output
  ctrl_t        ctrl_line_q   [W];
  logic [W-1:0] simple_line_q [W];
  logic [W-1:0] mres_line_q   [MUL_DLY];
  logic         movf_line_q   [MUL_DLY];

  // final stage
  ctrl_t        f_ctrl;
  logic [W-1:0] f_res_d, f_res_q;
  err_e         f_err_d, f_err_q;
  logic         done_q;

  assign busy_o = 1'b0;

  cia_prep #(.DATA_WIDTH(W)) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (start_i && !busy_o),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .ctrl_o      (p_ctrl),
    .simple_o    (p_simple),
    .mag_a_o     (p_mag_a),
    .mag_b_o     (p_mag_b),
    .mul_neg_o   (p_mul_neg)
  );

  cia_mul #(.DATA_WIDTH(W)) u_mul (
    .clk_i   (clk_i),
    .mag_a_i (p_mag_a),
    .mag_b_i (p_mag_b),
    .neg_i   (p_mul_neg),
    .res_o   (m_res),
    .ovf_o   (m_ovf)
  );

  cia_div #(.DATA_WIDTH(W)) u_div (
    .clk_i      (clk_i),
    .dividend_i (p_mag_a),
    .divisor_i  (p_mag_b),
    .quot_o     (d_quot),
    .rem_o      (d_rem)
  );

  // control line carries the valid bits, so it is reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < W; i++) ctrl_line_q[i] <= '0;
    end else begin
      ctrl_line_q[0] <= p_ctrl;
      for (int i = 1; i < W; i++) ctrl_line_q[i] <= ctrl_line_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    simple_line_q[0] <= p_simple;
    for (int i = 1; i < W; i++) simple_line_q[i] <= simple_line_q[i-1];
    mres_line_q[0] <= m_res;
    movf_line_q[0] <= m_ovf;
    for (int i = 1; i < MUL_DLY; i++) begin
      mres_line_q[i] <= mres_line_q[i-1];
      movf_line_q[i] <= movf_line_q[i-1];
    end
  end

  assign f_ctrl = ctrl_line_q[W-1];

  // pick the unit result, apply signs, zero the result on any error
  always_comb begin
    f_err_d = f_ctrl.err;
    case (f_ctrl.op)
      OP_MUL: begin
        f_res_d = mres_line_q[MUL_DLY-1];
        f_err_d = movf_line_q[MUL_DLY-1] ? ERR_OVF : ERR_NONE;
      end
      OP_DIV:  f_res_d = f_ctrl.neg_q ? (~d_quot + 1'b1) : d_quot;
      OP_MOD:  f_res_d = f_ctrl.neg_r ? (~d_rem + 1'b1) : d_rem;
      default: f_res_d = simple_line_q[W-1];
    endcase
    if (f_err_d != ERR_NONE) f_res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= f_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    f_res_q <= f_res_d;
    f_err_q <= f_err_d;
  end

  assign done_o   = done_q;
  assign result_o = {{(64-W){1'b0}}, f_res_q};
  assign error_o  = f_err_q;

endmodule

`default_nettype wire

// ===== rtl/cia_checker.sv =====
// ----------------------------------------------------------------------------
// cia_checker
// port-level checks for the checked integer alu, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cia_checker #(
  parameter int DATA_WIDTH = 64
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [63:0] result_o,
  input wire logic [1:0]  error_o
);
  import cia_pkg::*;

  localparam int LAT = DATA_WIDTH + 2;

  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("item lost in pipeline");

  // and nothing comes out that was not accepted
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without an item");

  // errored results are zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o != ERR_NONE) |-> (result_o == '0))
    else $error("nonzero result with error");

  // unused error code never appears
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (error_o == ERR_NONE || error_o == ERR_OVF || error_o == ERR_DIV0))
    else $error("bad error code");

endmodule

bind checked_integer_alu cia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cia_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o),
  .error_o  (error_o)
);

`default_nettype wire
